FILE: sv/htsp_pkg.sv
package htsp_pkg;

    localparam int TAG_SLOTS = 4;
    localparam int TAG_CHARS = 8;
    localparam int NAME_W    = 8 * TAG_CHARS;
    localparam int LEN_W     = 4;
    localparam int POS_W     = (TAG_CHARS > 1) ? $clog2(TAG_CHARS) : 1;
    localparam int MODE_W    = 3;
    localparam int CFG_W     = 64;
    localparam int ADDR_W    = 6;
    localparam int REG_IDX_W = 3;

    localparam logic [MODE_W-1:0] MODE_TEXT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_NAME = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REST = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DQ   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SQ   = 3'd4;

    localparam logic [REG_IDX_W-1:0] REG_TAG_WORD_0    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TAG_WORD_1    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TAG_WORD_2    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TAG_WORD_3    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_TAG_WORDS_USED = 3'd4;

    localparam logic [7:0] CH_OPEN   = 8'h3C;
    localparam logic [7:0] CH_CLOSE  = 8'h3E;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_BLANK  = 8'h20;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CASE_BIT  = 8'h20;

    typedef struct packed {
        logic [TAG_SLOTS-1:0][NAME_W-1:0] words;
        logic [2:0]                       used;
    } t_cfg;

endpackage

FILE: sv/htsp_cfg.sv
module htsp_cfg
    import htsp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [CFG_W-1:0]  i_pwdata,
    output logic [CFG_W-1:0]  o_prdata,
    output logic              o_pready,
    output t_cfg              o_cfg
);

    logic [3:0][CFG_W-1:0] r_word;
    logic [2:0]            r_used;
    logic                  wr_en;
    logic [REG_IDX_W-1:0]  reg_idx;

    assign reg_idx  = i_paddr[ADDR_W-1:3];
    assign wr_en    = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
            r_used <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_TAG_WORD_0:     r_word[0] <= i_pwdata;
                REG_TAG_WORD_1:     r_word[1] <= i_pwdata;
                REG_TAG_WORD_2:     r_word[2] <= i_pwdata;
                REG_TAG_WORD_3:     r_word[3] <= i_pwdata;
                REG_TAG_WORDS_USED: r_used    <= i_pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TAG_WORD_0:     o_prdata = r_word[0];
            REG_TAG_WORD_1:     o_prdata = r_word[1];
            REG_TAG_WORD_2:     o_prdata = r_word[2];
            REG_TAG_WORD_3:     o_prdata = r_word[3];
            REG_TAG_WORDS_USED: o_prdata = {{(CFG_W-3){1'b0}}, r_used};
            default:            o_prdata = '0;
        endcase
    end

    always_comb begin
        for (int s = 0; s < TAG_SLOTS; s++) begin
            o_cfg.words[s] = r_word[s][NAME_W-1:0];
        end
        o_cfg.used = r_used;
    end

endmodule

FILE: sv/htsp_parse.sv
module htsp_parse
    import htsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic [7:0] i_char,
    input  logic       i_start,
    input  logic       i_advance,
    output logic       o_emit,
    output logic [7:0] o_char
);

    logic [MODE_W-1:0] r_mode, n_mode, cur_mode;
    logic [NAME_W-1:0] r_buf,  n_buf,  cur_buf;
    logic [LEN_W-1:0]  r_len,  n_len,  cur_len;
    logic              r_skip, n_skip, cur_skip;
    logic              is_letter;
    logic              match;
    logic [2:0]        used_slots;
    logic [7:0]        close_quote;

    // text start wipes the parser before this character
    always_comb begin
        if (i_start) begin
            cur_mode = MODE_TEXT;
            cur_buf  = '0;
            cur_len  = '0;
            cur_skip = 1'b0;
        end else begin
            cur_mode = r_mode;
            cur_buf  = r_buf;
            cur_len  = r_len;
            cur_skip = r_skip;
        end
    end

    assign is_letter = i_char inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    assign used_slots = (i_cfg.used > 3'(TAG_SLOTS)) ? 3'(TAG_SLOTS) : i_cfg.used;
    assign close_quote = (cur_mode == MODE_SQ) ? CH_SQUOTE : CH_DQUOTE;

    // parallel compare against the enabled tag words
    always_comb begin
        match = 1'b0;
        for (int s = 0; s < TAG_SLOTS; s++) begin
            if ((3'(s) < used_slots) && (i_cfg.words[s] == cur_buf)) begin
                match = 1'b1;
            end
        end
        if (cur_len == '0 || cur_len > LEN_W'(TAG_CHARS)) begin
            match = 1'b0;
        end
    end

    always_comb begin
        n_mode = cur_mode;
        n_buf  = cur_buf;
        n_len  = cur_len;
        n_skip = cur_skip;
        o_emit = 1'b0;
        o_char = i_char;
        case (cur_mode)
            MODE_NAME: begin
                if (is_letter) begin
                    if (cur_len < LEN_W'(TAG_CHARS)) begin
                        for (int k = 0; k < TAG_CHARS; k++) begin
                            if (POS_W'(k) == cur_len[POS_W-1:0]) begin
                                n_buf[8*k +: 8] = i_char | CASE_BIT;
                            end
                        end
                        n_len = cur_len + LEN_W'(1);
                    end else begin
                        n_len = LEN_W'(TAG_CHARS + 1);
                    end
                end else if (i_char == CH_SQUOTE) begin
                    n_mode = MODE_SQ;
                end else if (i_char == CH_DQUOTE) begin
                    n_mode = MODE_DQ;
                end else begin
                    n_mode = (i_char == CH_CLOSE) ? MODE_TEXT : MODE_REST;
                    o_emit = 1'b1;
                    o_char = match ? CH_NL : CH_BLANK;
                end
            end
            MODE_SQ, MODE_DQ: begin
                if (cur_skip) begin
                    n_skip = 1'b0;
                end else if (i_char == CH_BSLASH) begin
                    n_skip = 1'b1;
                end else if (i_char == close_quote) begin
                    n_mode = MODE_REST;
                end
            end
            MODE_REST: begin
                if (i_char == CH_SQUOTE) begin
                    n_mode = MODE_SQ;
                end else if (i_char == CH_DQUOTE) begin
                    n_mode = MODE_DQ;
                end else if (i_char == CH_CLOSE) begin
                    n_mode = MODE_TEXT;
                end
            end
            default: begin
                n_mode = MODE_TEXT;
                if (i_char == CH_OPEN) begin
                    n_mode = MODE_NAME;
                    n_buf  = '0;
                    n_len  = '0;
                end else begin
                    o_emit = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_TEXT;
            r_buf  <= '0;
            r_len  <= '0;
            r_skip <= 1'b0;
        end else if (i_advance) begin
            r_mode <= n_mode;
            r_buf  <= n_buf;
            r_len  <= n_len;
            r_skip <= n_skip;
        end
    end

endmodule

FILE: sv/html_tag_stripper_core.sv
// an accepted input beat passes the input register and then the output register, if it makes an output
// one character per cycle unless the output stalls; parser state closes its loop each cycle
// an input register and an output register split the two stream sides
// reset (i_rst_n low, synchronous): parser in text mode, name cleared, both stages empty,
// tag words and tag_words_used cleared
module html_tag_stripper_core
    import htsp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [7:0]        i_s_tdata,   // [7:0] in_char
    input  logic              i_s_tuser,   // [0] text_start
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [7:0]        o_m_tdata,   // [7:0] out_char
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [CFG_W-1:0]  i_pwdata,
    output logic [CFG_W-1:0]  o_prdata,
    output logic              o_pready
);

    t_cfg       cfg;
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_start;
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       emit;
    logic [7:0] emit_char;
    logic       advance;
    logic       out_free;

    htsp_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (cfg)
    );

    htsp_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_char    (r_in_char),
        .i_start   (r_in_start),
        .i_advance (advance),
        .o_emit    (emit),
        .o_char    (emit_char)
    );

    assign out_free   = !r_out_valid || i_m_tready;
    // a beat that makes no output never waits on the output side
    assign advance    = r_in_valid && (out_free || !emit);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_char  <= i_s_tdata;
            r_in_start <= i_s_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_char <= emit_char;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_char;

endmodule
